FILE: rtl/tln_pkg.sv
// ----------------------------------------------------------------------------
// tln_pkg
// Shared types and constants of the text line normalizer.
// ----------------------------------------------------------------------------
package tln_pkg;

    localparam int          CFG_W     = 6;
    localparam logic [5:0]  CFG_RESET = 6'd63;
    localparam int          BYTE_W    = 8;
    localparam int          CHAR_W    = 7;

    localparam logic [7:0]  CH_NL     = 8'h0A;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_TAB    = 8'h09;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_NUL    = 8'h00;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETTLE,
        S_ACT,
        S_EMIT_RD,
        S_EMIT_WR,
        S_FINISH
    } t_state;

    // source of a stored character
    typedef enum logic [1:0] {
        SRC_LIVE,
        SRC_HELD,
        SRC_SPACE
    } t_src;

    typedef struct packed {
        logic load_in;      // latch input beat
        logic ws_update;    // fold live whitespace byte into run flags
        logic clr_run;      // run settled
        logic clr_run_all;  // drop run state at end of input
        logic store;        // append a character to the line
        t_src store_src;
        logic clear_line;
        logic emit_start;   // read index to zero
        logic emit_next;    // read index up by one
        logic load_out;     // output register from line store
        logic load_noline;  // output register with empty-input marker
    } t_dp_cmd;

    typedef struct packed {
        logic live_ws;
        logic live_end;
        logic live_zero;
        logic live_high;
        logic held_end;
        logic held_zero;
        logic held_high;
        logic in_run;
        logic run_nl;
        logic len_zero;
        logic last_space;
        logic emit_empty;
        logic emit_last;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/tln_dp.sv
// ----------------------------------------------------------------------------
// tln_dp
// Datapath: input latch, run flags, line store, read index, output register.
// ----------------------------------------------------------------------------
module tln_dp #(
    parameter int LINE_CAPACITY = 63
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [7:0]             i_data,
    input  logic                   i_end,
    input  logic                   i_cfg_wr_en,
    input  logic [5:0]             i_cfg_wr_data,
    input  logic                   i_out_ready,
    input  tln_pkg::t_dp_cmd       i_cmd,
    output tln_pkg::t_dp_sts       o_sts,
    output logic                   o_out_valid,
    output logic [6:0]             o_out_char,
    output logic                   o_out_last,
    output logic                   o_out_noline
);
    import tln_pkg::*;

    localparam int LW = $clog2(LINE_CAPACITY + 1);
    localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

    logic [BYTE_W-1:0] r_byte;
    logic              r_end;
    logic [LW-1:0]     r_len;
    logic              r_ovf;
    logic              r_run;
    logic              r_run_nl;
    logic              r_last_sp;
    logic [AW-1:0]     r_idx;
    logic [CFG_W-1:0]  r_cfg;
    logic [CHAR_W-1:0] r_mem [LINE_CAPACITY];
    logic [CHAR_W-1:0] r_rd_data;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;
    logic              r_out_noline;

    logic [CFG_W-1:0]  w_lim;
    logic [CFG_W-1:0]  w_len6;
    logic              w_fits;
    logic              w_ovf_set;
    logic              w_trim;
    logic [LW-1:0]     w_elen;
    logic [BYTE_W-1:0] w_st_byte;
    logic              w_live_nl;

    assign w_lim  = (r_cfg > CFG_W'(LINE_CAPACITY)) ? CFG_W'(LINE_CAPACITY) : r_cfg;
    assign w_len6 = CFG_W'(r_len);
    assign w_fits = w_len6 < w_lim;
    // not storing means len >= lim already, so this covers both cases
    assign w_ovf_set = ({1'b0, w_len6} + (CFG_W+1)'(1)) >= {1'b0, w_lim};
    // only a settled run ever stores a space, and a trailing one is trimmed
    assign w_trim = r_last_sp & ~r_ovf;
    assign w_elen = r_len - LW'(w_trim);
    assign w_live_nl = (i_data == CH_NL);

    always_comb begin
        case (i_cmd.store_src)
            SRC_LIVE:  w_st_byte = i_data;
            SRC_HELD:  w_st_byte = r_byte;
            SRC_SPACE: w_st_byte = CH_SPACE;
            default:   w_st_byte = CH_SPACE;
        endcase
    end

    always_comb begin
        o_sts.live_ws    = (i_data == CH_SPACE) || (i_data >= CH_TAB && i_data <= CH_CR);
        o_sts.live_end   = i_end;
        o_sts.live_zero  = (i_data == CH_NUL);
        o_sts.live_high  = i_data[BYTE_W-1];
        o_sts.held_end   = r_end;
        o_sts.held_zero  = (r_byte == CH_NUL);
        o_sts.held_high  = r_byte[BYTE_W-1];
        o_sts.in_run     = r_run;
        o_sts.run_nl     = r_run_nl;
        o_sts.len_zero   = (r_len == '0);
        o_sts.last_space = r_last_sp;
        o_sts.emit_empty = r_ovf | (w_elen == '0);
        o_sts.emit_last  = (LW'(r_idx) == (w_elen - LW'(1)));
        o_sts.out_free   = ~r_out_valid | i_out_ready;
    end

    // line store, registered read at the emit index
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && w_fits) begin
            r_mem[r_len[AW-1:0]] <= w_st_byte[CHAR_W-1:0];
        end
        r_rd_data <= r_mem[r_idx];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_byte <= i_data;
        end
        if (i_cmd.emit_start) begin
            r_idx <= '0;
        end else if (i_cmd.emit_next) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.load_out) begin
            r_out_char   <= r_rd_data;
            r_out_last   <= o_sts.emit_last;
            r_out_noline <= 1'b0;
        end else if (i_cmd.load_noline) begin
            r_out_char   <= '0;
            r_out_last   <= 1'b0;
            r_out_noline <= 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end       <= 1'b0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_run       <= 1'b0;
            r_run_nl    <= 1'b0;
            r_last_sp   <= 1'b0;
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (i_cmd.load_in) begin
                r_end <= i_end;
            end
            if (i_cmd.ws_update) begin
                r_run    <= 1'b1;
                r_run_nl <= r_run ? (r_run_nl | w_live_nl) : w_live_nl;
            end else if (i_cmd.clr_run_all) begin
                r_run    <= 1'b0;
                r_run_nl <= 1'b0;
            end else if (i_cmd.clr_run) begin
                r_run    <= 1'b0;
            end
            if (i_cmd.clear_line) begin
                r_len     <= '0;
                r_ovf     <= 1'b0;
                r_last_sp <= 1'b0;
            end else if (i_cmd.store) begin
                if (w_fits) begin
                    r_len     <= r_len + LW'(1);
                    r_last_sp <= (i_cmd.store_src == SRC_SPACE);
                end
                if (w_ovf_set) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.load_out || i_cmd.load_noline) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_out_last   = r_out_last;
    assign o_out_noline = r_out_noline;

endmodule

FILE: rtl/tln_ctrl.sv
// ----------------------------------------------------------------------------
// tln_ctrl
// Controller: sequences run settling, storing and line emission per beat.
// ----------------------------------------------------------------------------
module tln_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tln_pkg::t_dp_sts    i_sts,
    output tln_pkg::t_dp_cmd    o_cmd
);
    import tln_pkg::*;

    t_state r_state, n_state;
    logic   r_from_settle, n_from_settle;  // where an emission returns to
    logic   r_any, n_any;                  // current beat produced a character

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_from_settle <= 1'b0;
            r_any         <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_from_settle <= n_from_settle;
            r_any         <= n_any;
        end
    end

    always_comb begin
        t_state w_ret;
        n_state       = r_state;
        n_from_settle = r_from_settle;
        n_any         = r_any;
        o_cmd         = '0;
        o_cmd.store_src = SRC_HELD;
        o_in_ready    = 1'b0;
        w_ret = r_from_settle ? S_ACT : (i_sts.held_end ? S_FINISH : S_IDLE);

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_any = 1'b0;
                    if (i_sts.live_end) begin
                        n_state = S_SETTLE;
                    end else if (i_sts.live_ws) begin
                        o_cmd.ws_update = 1'b1;
                    end else if (i_sts.in_run) begin
                        n_state = S_SETTLE;
                    end else if (i_sts.live_zero) begin
                        n_state = S_ACT;
                    end else if (!i_sts.live_high) begin
                        o_cmd.store     = 1'b1;
                        o_cmd.store_src = SRC_LIVE;
                    end
                end
            end
            S_SETTLE: begin
                n_state = S_ACT;
                if (i_sts.in_run) begin
                    o_cmd.clr_run = 1'b1;
                    if (!i_sts.len_zero) begin
                        if (i_sts.run_nl) begin
                            if (i_sts.emit_empty) begin
                                o_cmd.clear_line = 1'b1;
                            end else begin
                                o_cmd.emit_start = 1'b1;
                                n_from_settle    = 1'b1;
                                n_state          = S_EMIT_RD;
                            end
                        end else if (!i_sts.last_space) begin
                            o_cmd.store     = 1'b1;
                            o_cmd.store_src = SRC_SPACE;
                        end
                    end
                end
            end
            S_ACT: begin
                if (i_sts.held_end || i_sts.held_zero) begin
                    if (i_sts.emit_empty) begin
                        o_cmd.clear_line = 1'b1;
                        n_state = i_sts.held_end ? S_FINISH : S_IDLE;
                    end else begin
                        o_cmd.emit_start = 1'b1;
                        n_from_settle    = 1'b0;
                        n_state          = S_EMIT_RD;
                    end
                end else begin
                    if (!i_sts.held_high) begin
                        o_cmd.store     = 1'b1;
                        o_cmd.store_src = SRC_HELD;
                    end
                    n_state = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_any = 1'b1;
                    if (i_sts.emit_last) begin
                        o_cmd.clear_line = 1'b1;
                        n_state = w_ret;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_FINISH: begin
                if (r_any) begin
                    o_cmd.clr_run_all = 1'b1;
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.load_noline = 1'b1;
                    o_cmd.clr_run_all = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/text_line_normalizer_top.sv
// ----------------------------------------------------------------------------
// text_line_normalizer_top
// Byte stream in, normalized text lines out, one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one raw byte on s_axis tdata; tuser set marks end of
//   stream (byte ignored, pending line flushed). Output beats carry one
//   character each; tlast flags the final character of a line, and tuser
//   flags the single "no line" beat sent when end of stream has nothing to
//   flush. max_line_length is written through i_cfg_wr_en/i_cfg_wr_data
//   while the block is idle; a line reaching that length is discarded.
// Sequence:
//   A printable, dropped or whitespace byte is handled in the idle state.
//   A zero byte outside a run also passes the act state, a byte that settles
//   a run the settle and act states, end of stream settle, act and finish,
//   each plus the line readout, which reads each character from the
//   registered line store in a read state and loads it out in a write state.
//   A line flushed by a run with newline is emitted from the settle state,
//   otherwise from the act state.
// Reset:
//   i_rst_n low (synchronous) empties the line, clears run state and sets
//   the limit to 63. Line store contents are not cleared.
// Stall:
//   The output register holds a beat until taken; the readout waits on it,
//   and input is not taken during a readout.
// ----------------------------------------------------------------------------
module text_line_normalizer_top #(
    parameter int LINE_CAPACITY = 63
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tuser,   // [0] end_of_input
    // output stream
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic       o_m_axis_tlast,   // last_of_line
    output logic       o_m_axis_tuser,   // [0] no_line
    // configuration
    input  logic       i_cfg_wr_en,
    input  logic [5:0] i_cfg_wr_data     // max_line_length
);
    import tln_pkg::*;

    t_dp_cmd    w_cmd;   // controller -> datapath
    t_dp_sts    w_sts;   // datapath -> controller
    logic [6:0] w_char;

    tln_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tln_dp #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data        (i_s_axis_tdata),
        .i_end         (i_s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (i_m_axis_tready),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_m_axis_tvalid),
        .o_out_char    (w_char),
        .o_out_last    (o_m_axis_tlast),
        .o_out_noline  (o_m_axis_tuser)
    );

    // pad character to a whole byte
    assign o_m_axis_tdata = {1'b0, w_char};

endmodule
